[rtl/ffe_pkg.sv]
`timescale 1ns / 1ps

package ffe_pkg;

  // default frame geometry
  localparam int FRAME_WIDTH_DEF  = 320;
  localparam int FRAME_HEIGHT_DEF = 200;

  // widest geometry the engine supports (4096 x 4096)
  localparam int ADDR_MAX_W = 24;
  localparam int DIM_MAX_W  = 12;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] RESET_COLOR = 32'hFF00_0000;

  // command opcodes on the input channel
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // classified command kinds handed to the back end
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_FILL,
    KIND_READ,
    KIND_REJECT
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [ADDR_MAX_W-1:0] addr;
    logic [DIM_MAX_W-1:0]  wm1;
    logic [DIM_MAX_W-1:0]  hm1;
    logic [31:0]           color;
  } cmd_t;

endpackage

[rtl/ffe_front.sv]
`timescale 1ns / 1ps

module ffe_front #(
  parameter int FRAME_WIDTH  = ffe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ffe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic [1:0]    op_i,
  input  logic [15:0]   x_coord_i,
  input  logic [15:0]   y_coord_i,
  input  logic [15:0]   rect_width_i,
  input  logic [15:0]   rect_height_i,
  input  logic [31:0]   pixel_color_i,
  output ffe_pkg::cmd_t cmd_o
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int RW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  logic [16:0]   x_end;
  logic [16:0]   y_end;
  logic          x_in;
  logic          y_in;
  logic          fill_ok;
  logic [AW-1:0] start_addr;

  // bounds checks, ends taken one bit wider so they never wrap
  assign x_end   = {1'b0, x_coord_i} + {1'b0, rect_width_i};
  assign y_end   = {1'b0, y_coord_i} + {1'b0, rect_height_i};
  assign x_in    = ({1'b0, x_coord_i} < 17'(FRAME_WIDTH));
  assign y_in    = ({1'b0, y_coord_i} < 17'(FRAME_HEIGHT));
  assign fill_ok = (rect_width_i != 16'd0) && (rect_height_i != 16'd0) && x_in && y_in &&
                   (x_end <= 17'(FRAME_WIDTH)) && (y_end <= 17'(FRAME_HEIGHT));

  // row-major start address, only meaningful when the origin is in frame
  assign start_addr = AW'(y_coord_i[RW-1:0]) * AW'(FRAME_WIDTH) + AW'(x_coord_i[CW-1:0]);

  // classify the command
  always_comb begin
    cmd_o       = '0;
    cmd_o.addr  = ffe_pkg::ADDR_MAX_W'(start_addr);
    cmd_o.color = pixel_color_i;
    cmd_o.kind  = ffe_pkg::KIND_REJECT;
    case (op_i)
      ffe_pkg::OP_CLEAR: begin
        cmd_o.kind = ffe_pkg::KIND_CLEAR;
      end
      ffe_pkg::OP_PUT: begin
        // a single pixel is a 1x1 fill
        if (x_in && y_in) begin
          cmd_o.kind = ffe_pkg::KIND_FILL;
        end
      end
      ffe_pkg::OP_FILL: begin
        if (fill_ok) begin
          cmd_o.kind = ffe_pkg::KIND_FILL;
          cmd_o.wm1  = ffe_pkg::DIM_MAX_W'(rect_width_i - 16'd1);
          cmd_o.hm1  = ffe_pkg::DIM_MAX_W'(rect_height_i - 16'd1);
        end
      end
      ffe_pkg::OP_READ: begin
        if (x_in && y_in) begin
          cmd_o.kind = ffe_pkg::KIND_READ;
        end
      end
      default: begin
        cmd_o.kind = ffe_pkg::KIND_REJECT;
      end
    endcase
  end

endmodule

[rtl/ffe_queue.sv]
`timescale 1ns / 1ps

module ffe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ffe_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ffe_pkg::cmd_t pop_data_o
);

  localparam int DEPTH = ffe_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  ffe_pkg::cmd_t slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          push;
  logic          pop;

  assign push_ready_o = (cnt_q != NW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/ffe_back.sv]
`timescale 1ns / 1ps

module ffe_back #(
  parameter int FRAME_WIDTH  = ffe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ffe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ffe_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          status_o,
  output logic [31:0]   pixel_value_o,
  output logic [31:0]   background_color_o,
  output logic          init_busy_o
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int LAST  = DEPTH - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int RW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_POST  = 2'd3;

  logic [31:0]   frame_mem [0:DEPTH-1];
  logic [31:0]   rd_data_q;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] row_base_q, row_base_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] wm1_q, wm1_d;
  logic [RW-1:0] hm1_q, hm1_d;
  logic [31:0]   color_q, color_d;
  logic [31:0]   bg_q, bg_d;
  logic          post_q, post_d;
  logic          status_q, status_d;
  logic          is_read_q, is_read_d;

  logic          out_vld_q;
  logic          out_status_q;
  logic [31:0]   out_value_q;
  logic [31:0]   out_bg_q;

  logic          pop;
  logic          rd_en;
  logic          wr_en;
  logic          out_free;
  logic          out_load;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign wr_en       = (state_q == ST_SWEEP) || (state_q == ST_FILL);
  assign out_free    = !out_vld_q || out_ready_i;
  assign out_load    = (state_q == ST_POST) && out_free;
  assign init_busy_o = (state_q == ST_SWEEP) && !post_q;

  // command sequencer
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    row_base_d = row_base_q;
    col_d      = col_q;
    row_d      = row_q;
    wm1_d      = wm1_q;
    hm1_d      = hm1_q;
    color_d    = color_q;
    bg_d       = bg_q;
    post_d     = post_q;
    status_d   = status_q;
    is_read_d  = is_read_q;
    rd_en      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          status_d  = 1'b0;
          is_read_d = 1'b0;
          color_d   = cmd_i.color;
          case (cmd_i.kind)
            ffe_pkg::KIND_CLEAR: begin
              bg_d    = cmd_i.color;
              addr_d  = '0;
              post_d  = 1'b1;
              state_d = ST_SWEEP;
            end
            ffe_pkg::KIND_FILL: begin
              addr_d     = cmd_i.addr[AW-1:0];
              row_base_d = cmd_i.addr[AW-1:0];
              col_d      = '0;
              row_d      = '0;
              wm1_d      = cmd_i.wm1[CW-1:0];
              hm1_d      = cmd_i.hm1[RW-1:0];
              state_d    = ST_FILL;
            end
            ffe_pkg::KIND_READ: begin
              rd_en     = 1'b1;
              is_read_d = 1'b1;
              state_d   = ST_POST;
            end
            default: begin
              status_d = 1'b1;
              state_d  = ST_POST;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // one pixel a cycle over the whole frame
        if (addr_q == AW'(LAST)) begin
          state_d = post_q ? ST_POST : ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_FILL: begin
        // row by row, one pixel a cycle
        if (col_q == wm1_q) begin
          if (row_q == hm1_q) begin
            state_d = ST_POST;
          end else begin
            row_base_d = row_base_q + AW'(FRAME_WIDTH);
            addr_d     = row_base_q + AW'(FRAME_WIDTH);
            col_d      = '0;
            row_d      = row_q + RW'(1);
          end
        end else begin
          addr_d = addr_q + AW'(1);
          col_d  = col_q + CW'(1);
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state; reset starts the clearing pass with the reset color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      addr_q    <= '0;
      color_q   <= ffe_pkg::RESET_COLOR;
      bg_q      <= ffe_pkg::RESET_COLOR;
      post_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      color_q <= color_d;
      bg_q    <= bg_d;
      post_q  <= post_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    row_base_q <= row_base_d;
    col_q      <= col_d;
    row_q      <= row_d;
    wm1_q      <= wm1_d;
    hm1_q      <= hm1_d;
    status_q   <= status_d;
    is_read_q  <= is_read_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_value_q  <= is_read_q ? rd_data_q : 32'd0;
      out_bg_q     <= bg_q;
    end
  end

  // frame store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[addr_q] <= color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= frame_mem[cmd_i.addr[AW-1:0]];
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = out_status_q;
  assign pixel_value_o      = out_value_q;
  assign background_color_o = out_bg_q;

endmodule

[rtl/framebuffer_fill_engine_core.sv]
`timescale 1ns / 1ps

// channel | handshake               | payload
// --------+-------------------------+-------------------------------------------------
// in      | in_valid_i / in_ready_o | op_i x_coord_i y_coord_i rect_width_i
//         |                         | rect_height_i pixel_color_i
// out     | out_valid_o/out_ready_i | status_o pixel_value_o background_color_o
//
// the back end takes one command at a time from the queue; put, fill and clear write their
// pixels in turn through the single frame store write port, and every command then ends in
// the post state, from which its result is loaded into the result register and offered.
// a result still waiting for out_ready_i holds the back end in its post state.
// reset runs a clearing pass over the whole frame with in_ready_o low.
// the two-entry queue keeps accepting until full while the back end works or a result waits.

module framebuffer_fill_engine_core #(
  parameter int FRAME_WIDTH  = ffe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ffe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] x_coord_i,
  input  logic [15:0] y_coord_i,
  input  logic [15:0] rect_width_i,
  input  logic [15:0] rect_height_i,
  input  logic [31:0] pixel_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [31:0] pixel_value_o,
  output logic [31:0] background_color_o
);

  ffe_pkg::cmd_t front_cmd;
  ffe_pkg::cmd_t queue_cmd;
  logic          queue_push_ready;
  logic          queue_valid;
  logic          back_ready;
  logic          init_busy;

  // front end: classify and address
  ffe_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .op_i          (op_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .pixel_color_i (pixel_color_i),
    .cmd_o         (front_cmd)
  );

  // no transaction taken while the clearing pass runs
  assign in_ready_o = queue_push_ready && !init_busy;

  // command queue
  ffe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i && !init_busy),
    .push_ready_o (queue_push_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_cmd)
  );

  // back end: frame store and sequencer
  ffe_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (queue_valid),
    .cmd_ready_o        (back_ready),
    .cmd_i              (queue_cmd),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .pixel_value_o      (pixel_value_o),
    .background_color_o (background_color_o),
    .init_busy_o        (init_busy)
  );

  // no result is offered during the clearing pass
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !out_valid_o)
    else $error("result offered during clearing pass");

  // a rejected transaction carries a zero pixel value
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (pixel_value_o == 32'd0))
    else $error("rejected result with nonzero pixel value");

  // the queue is empty when the clearing pass ends
  a_queue_empty_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(init_busy) |-> !queue_valid)
    else $error("command queued during clearing pass");

endmodule
